@@ design/dllm_pkg.sv @@
package dllm_pkg;

  // Pool geometry; links use the code NODES as "no node"
  localparam int NODES      = 16;
  localparam int NODE_W     = 4;
  localparam int LINK_W     = NODE_W + 1;
  localparam int CNT_W      = 5;
  localparam int VALUE_BITS = 32;

  localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(NODES);

  // Operation codes
  localparam logic [2:0] OP_PUSH_HEAD    = 3'd0;
  localparam logic [2:0] OP_PUSH_TAIL    = 3'd1;
  localparam logic [2:0] OP_POP_HEAD     = 3'd2;
  localparam logic [2:0] OP_POP_TAIL     = 3'd3;
  localparam logic [2:0] OP_DELETE       = 3'd4;
  localparam logic [2:0] OP_CURSOR_START = 3'd5;
  localparam logic [2:0] OP_CURSOR_NEXT  = 3'd6;
  localparam logic [2:0] OP_CLEAR        = 3'd7;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  typedef struct packed {
    logic [2:0]            operation;
    logic [VALUE_BITS-1:0] item_value;
    logic [NODE_W-1:0]     node_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] result_value;
    logic [NODE_W-1:0]     result_handle;
    logic [CNT_W-1:0]      list_length;
  } rsp_t;

endpackage

@@ design/doubly_linked_list_manager_top.sv @@
// Bounded doubly linked list (deque) over a 16-node pool with a walking cursor.
// A request is taken into the request register, which feeds the result register through one
// pass of logic; one request per cycle is sustained while the result side is not stalled,
// since the list state is updated in a single pass.
// Reset (rst, synchronous, active high): list empty, all nodes free, cursor at
// end, head-first direction; node values and links are undefined until written.
module doubly_linked_list_manager_top
  import dllm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic cfg_data,
  input  logic request_valid,
  output logic request_stall,
  input  req_t request,
  output logic result_valid,
  input  logic result_stall,
  output rsp_t result
);

  // Request register
  logic req_full;
  req_t req_q;
  logic exec;

  // List state
  logic [VALUE_BITS-1:0] node_values [NODES];
  logic [LINK_W-1:0]     prev_links  [NODES];
  logic [LINK_W-1:0]     next_links  [NODES];
  logic [LINK_W-1:0]     head_index, tail_index, cursor_index;
  logic [CNT_W-1:0]      node_count;
  logic [NODES-1:0]      in_use_map;
  logic                  cursor_backward;
  logic                  walk_from_tail;

  logic [LINK_W-1:0] head_index_next, tail_index_next, cursor_index_next;
  logic [CNT_W-1:0]  node_count_next;
  logic [NODES-1:0]  in_use_map_next;
  logic              cursor_backward_next;
  rsp_t              result_next;

  // Free-node search
  logic              alloc_found;
  logic [NODE_W-1:0] alloc_idx;

  // Selected node read
  logic [LINK_W-1:0]     sel_link;
  logic [NODE_W-1:0]     sel_idx;
  logic [VALUE_BITS-1:0] rd_value;
  logic [LINK_W-1:0]     rd_prev, rd_next;
  logic                  do_unlink;

  // Link write ports
  logic              val_we;
  logic              nxa_we, nxb_we, pva_we, pvb_we;
  logic [NODE_W-1:0] nxa_idx, nxb_idx, pva_idx, pvb_idx;
  logic [LINK_W-1:0] nxa_data, nxb_data, pva_data, pvb_data;

  assign exec          = req_full && (!result_valid || !result_stall);
  assign request_stall = req_full && !exec;

  // Take a new request whenever the request register drains
  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (!request_stall) begin
      req_full <= request_valid;
    end
    if (request_valid && !request_stall) begin
      req_q <= request;
    end
  end

  // Cursor direction register
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_from_tail <= 1'b0;
    end else if (cfg_write) begin
      walk_from_tail <= cfg_data;
    end
  end

  // Find the lowest free node
  always_comb begin
    alloc_found = 1'b0;
    alloc_idx   = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (!in_use_map[i]) begin
        alloc_found = 1'b1;
        alloc_idx   = NODE_W'(i);
      end
    end
  end

  // Pick the one node this request reads
  always_comb begin
    case (req_q.operation)
      OP_POP_HEAD:    sel_link = head_index;
      OP_POP_TAIL:    sel_link = tail_index;
      OP_DELETE:      sel_link = {1'b0, req_q.node_handle};
      default:        sel_link = cursor_index;
    endcase
  end

  assign sel_idx  = sel_link[NODE_W-1:0];
  assign rd_value = node_values[sel_idx];
  assign rd_prev  = prev_links[sel_idx];
  assign rd_next  = next_links[sel_idx];

  // Single-pass update of list state
  always_comb begin
    head_index_next      = head_index;
    tail_index_next      = tail_index;
    cursor_index_next    = cursor_index;
    node_count_next      = node_count;
    in_use_map_next      = in_use_map;
    cursor_backward_next = cursor_backward;
    result_next          = '0;
    do_unlink            = 1'b0;
    val_we   = 1'b0;
    nxa_we   = 1'b0;  nxa_idx = '0;  nxa_data = LINK_NIL;
    nxb_we   = 1'b0;  nxb_idx = '0;  nxb_data = LINK_NIL;
    pva_we   = 1'b0;  pva_idx = '0;  pva_data = LINK_NIL;
    pvb_we   = 1'b0;  pvb_idx = '0;  pvb_data = LINK_NIL;

    case (req_q.operation)
      OP_PUSH_HEAD, OP_PUSH_TAIL: begin
        if (!alloc_found) begin
          result_next.status = ST_FULL;
        end else begin
          in_use_map_next[alloc_idx] = 1'b1;
          val_we  = 1'b1;
          pva_we  = 1'b1;
          pva_idx = alloc_idx;
          nxa_we  = 1'b1;
          nxa_idx = alloc_idx;
          if (head_index[NODE_W] || tail_index[NODE_W]) begin
            head_index_next = {1'b0, alloc_idx};
            tail_index_next = {1'b0, alloc_idx};
          end else if (req_q.operation == OP_PUSH_HEAD) begin
            nxa_data        = head_index;
            pvb_we          = 1'b1;
            pvb_idx         = head_index[NODE_W-1:0];
            pvb_data        = {1'b0, alloc_idx};
            head_index_next = {1'b0, alloc_idx};
          end else begin
            pva_data        = tail_index;
            nxb_we          = 1'b1;
            nxb_idx         = tail_index[NODE_W-1:0];
            nxb_data        = {1'b0, alloc_idx};
            tail_index_next = {1'b0, alloc_idx};
          end
          node_count_next            = node_count + CNT_W'(1);
          result_next.result_handle = alloc_idx;
        end
      end
      OP_POP_HEAD, OP_POP_TAIL: begin
        if (sel_link[NODE_W]) begin
          result_next.status = ST_EMPTY;
        end else begin
          do_unlink = 1'b1;
        end
      end
      OP_DELETE: begin
        if (!in_use_map[sel_idx]) begin
          result_next.status = ST_BAD_HANDLE;
        end else begin
          do_unlink = 1'b1;
        end
      end
      OP_CURSOR_START: begin
        cursor_backward_next = walk_from_tail;
        cursor_index_next    = walk_from_tail ? tail_index : head_index;
        if (cursor_index_next[NODE_W]) begin
          cursor_index_next  = LINK_NIL;
          result_next.status = ST_EMPTY;
        end else begin
          result_next.result_handle = cursor_index_next[NODE_W-1:0];
        end
      end
      OP_CURSOR_NEXT: begin
        if (sel_link[NODE_W]) begin
          result_next.status = ST_EMPTY;
        end else begin
          cursor_index_next         = cursor_backward ? rd_prev : rd_next;
          result_next.result_value  = rd_value;
          result_next.result_handle = sel_idx;
        end
      end
      OP_CLEAR: begin
        in_use_map_next   = '0;
        head_index_next   = LINK_NIL;
        tail_index_next   = LINK_NIL;
        cursor_index_next = LINK_NIL;
        node_count_next   = '0;
      end
      default: begin
      end
    endcase

    // Unlink the selected node and bridge its neighbors
    if (do_unlink) begin
      if (cursor_index == sel_link) begin
        cursor_index_next = cursor_backward ? rd_prev : rd_next;
      end
      if (!rd_prev[NODE_W]) begin
        nxa_we   = 1'b1;
        nxa_idx  = rd_prev[NODE_W-1:0];
        nxa_data = rd_next;
      end else begin
        head_index_next = rd_next;
      end
      if (!rd_next[NODE_W]) begin
        pva_we   = 1'b1;
        pva_idx  = rd_next[NODE_W-1:0];
        pva_data = rd_prev;
      end else begin
        tail_index_next = rd_prev;
      end
      in_use_map_next[sel_idx] = 1'b0;
      if (node_count != '0) begin
        node_count_next = node_count - CNT_W'(1);
      end
      result_next.result_value  = rd_value;
      result_next.result_handle = sel_idx;
    end

    result_next.list_length = node_count_next;
  end

  // Commit control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index      <= LINK_NIL;
      tail_index      <= LINK_NIL;
      cursor_index    <= LINK_NIL;
      node_count      <= '0;
      in_use_map      <= '0;
      cursor_backward <= 1'b0;
    end else if (exec) begin
      head_index      <= head_index_next;
      tail_index      <= tail_index_next;
      cursor_index    <= cursor_index_next;
      node_count      <= node_count_next;
      in_use_map      <= in_use_map_next;
      cursor_backward <= cursor_backward_next;
    end
  end

  // Write node values and links
  always_ff @(posedge clk) begin
    if (exec) begin
      if (val_we) begin
        node_values[alloc_idx] <= req_q.item_value;
      end
      if (nxa_we) begin
        next_links[nxa_idx] <= nxa_data;
      end
      if (nxb_we) begin
        next_links[nxb_idx] <= nxb_data;
      end
      if (pva_we) begin
        prev_links[pva_idx] <= pva_data;
      end
      if (pvb_we) begin
        prev_links[pvb_idx] <= pvb_data;
      end
    end
  end

  // Result register; hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (exec) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (exec) begin
      result <= result_next;
    end
  end

  // Count tracks the in-use map
  a_count_matches_map: assert property (@(posedge clk) disable iff (rst)
    32'(node_count) == 32'($countones(in_use_map)))
    else $error("node count differs from in-use map");

  // Head and tail are empty together
  a_head_tail_nil: assert property (@(posedge clk) disable iff (rst)
    head_index[NODE_W] == tail_index[NODE_W])
    else $error("head and tail disagree on empty list");

  // Empty list has no count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    head_index[NODE_W] == (node_count == '0))
    else $error("head link disagrees with node count");

  // A stall only occurs with a request held and the result side blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    request_stall |-> (req_full && result_valid && result_stall))
    else $error("request stalled without back pressure");

endmodule
